// ----- rtl/bptc_pkg.sv -----
// shared widths, constants and stage types for the barometer compensation pipeline
package bptc_pkg;

    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int DT_W    = 25;
    localparam int PT_W    = 42;
    localparam int DD_W    = 50;
    localparam int T1_W    = 20;
    localparam int OFF1_W  = 36;
    localparam int T2_W    = 17;
    localparam int SQ_W    = 36;
    localparam int CORR_W  = 40;
    localparam int OFF_W   = 40;
    localparam int SPLIT_W = 20;
    localparam int PLO_W   = RAW_W + SPLIT_W;
    localparam int PHI_W   = RAW_W + 1 + (OFF_W - SPLIT_W);
    localparam int PROD_W  = PHI_W + SPLIT_W;
    localparam int TEMP_W  = 19;
    localparam int PRESS_W = 44;
    localparam int IDX_W   = 3;

    localparam logic signed [T1_W-1:0] TEMP_KNEE = 20'sd2000;
    localparam logic signed [T1_W-1:0] TEMP_COLD = -20'sd1500;

    typedef enum logic [IDX_W-1:0] {
        CFG_SENS     = 3'd0,
        CFG_OFF      = 3'd1,
        CFG_TCS      = 3'd2,
        CFG_TCO      = 3'd3,
        CFG_TREF     = 3'd4,
        CFG_TEMPSENS = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [CAL_W-1:0] sens;
        logic [CAL_W-1:0] off;
        logic [CAL_W-1:0] tcs;
        logic [CAL_W-1:0] tco;
        logic [CAL_W-1:0] tref;
        logic [CAL_W-1:0] tempsens;
    } t_cal;

    // first-order results
    typedef struct packed {
        logic                     valid;
        logic [RAW_W-1:0]         d1;
        logic signed [T1_W-1:0]   temp1;
        logic signed [OFF1_W-1:0] off1;
        logic signed [OFF1_W-1:0] sens1;
        logic [T2_W-1:0]          t2;
    } t_first;

    // after the low-temperature correction
    typedef struct packed {
        logic                    valid;
        logic [RAW_W-1:0]        d1;
        logic signed [T1_W-1:0]  temp;
        logic signed [OFF_W-1:0] off;
        logic signed [OFF_W-1:0] sens;
    } t_second;

endpackage

// ----- rtl/bptc_first.sv -----
// dT, first-order products and first-order temperature, offset and sensitivity
module bptc_first
    import bptc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [RAW_W-1:0] i_d1,
    input  logic [RAW_W-1:0] i_d2,
    input  t_cal             i_cal,
    output t_first           o_first
);

    logic                   r_v1, r_v2, r_v3;
    logic [RAW_W-1:0]       r_d1_1, r_d1_2;
    logic signed [DT_W-1:0] r_dt, n_dt;
    logic signed [PT_W-1:0] r_pt, r_po, r_ps, n_pt, n_po, n_ps;
    logic [DD_W-1:0]        r_pdd, n_pdd;
    t_first                 r_out, n_out;

    always_comb begin
        n_dt  = $signed({1'b0, i_d2}) - $signed({1'b0, i_cal.tref, 8'h00});
        n_pt  = $signed({1'b0, i_cal.tempsens}) * r_dt;
        n_po  = $signed({1'b0, i_cal.tco}) * r_dt;
        n_ps  = $signed({1'b0, i_cal.tcs}) * r_dt;
        n_pdd = DD_W'(r_dt * r_dt);

        n_out       = r_out;
        n_out.valid = r_v2;
        n_out.d1    = r_d1_2;
        n_out.temp1 = TEMP_KNEE + T1_W'($signed(r_pt[PT_W-1:23]));
        n_out.off1  = $signed({4'b0, i_cal.off, 16'h0000})
                    + OFF1_W'($signed(r_po[PT_W-1:7]));
        n_out.sens1 = $signed({5'b0, i_cal.sens, 15'h0000})
                    + OFF1_W'($signed(r_ps[PT_W-1:8]));
        // dT squared is below 2^48
        n_out.t2    = r_pdd[47:31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1_1 <= i_d1;
        r_dt   <= n_dt;
        r_d1_2 <= r_d1_1;
        r_pt   <= n_pt;
        r_po   <= n_po;
        r_ps   <= n_ps;
        r_pdd  <= n_pdd;
        r_out  <= n_out;
    end

    always_comb begin
        o_first       = r_out;
        o_first.valid = r_v3;
    end

endmodule

// ----- rtl/bptc_second.sv -----
// second-order correction below 20.00 C with the extra term below -15.00 C
module bptc_second
    import bptc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_first  i_first,
    output t_second o_second
);

    logic                     r_v4, r_v5, r_v6;
    logic                     r_warm_n4, r_cold4, r_warm_n5, r_cold5;
    logic [RAW_W-1:0]         r_d1_4, r_d1_5;
    logic signed [T1_W-1:0]   r_temp4, r_temp5;
    logic signed [OFF1_W-1:0] r_off4, r_sens4, r_off5, r_sens5;
    logic [T2_W-1:0]          r_t2_4;
    logic [SQ_W-1:0]          r_dd, r_ee, n_dd, n_ee;
    logic [CORR_W-1:0]        r_sq5, r_e7, r_e11, n_sq5, n_e7, n_e11;
    logic signed [T1_W-1:0]   d, e, n_temp5;
    logic [CORR_W-1:0]        off2, sens2;
    t_second                  r_out, n_out;

    always_comb begin
        d    = i_first.temp1 - TEMP_KNEE;
        e    = i_first.temp1 - TEMP_COLD;
        n_dd = SQ_W'(d * d);
        n_ee = SQ_W'(e * e);
    end

    always_comb begin
        n_sq5   = CORR_W'({r_dd, 2'b00}) + CORR_W'(r_dd);
        n_e7    = CORR_W'({r_ee, 3'b000}) - CORR_W'(r_ee);
        n_e11   = CORR_W'({r_ee, 3'b000}) + CORR_W'({r_ee, 1'b0}) + CORR_W'(r_ee);
        n_temp5 = r_warm_n4 ? r_temp4 - T1_W'(r_t2_4) : r_temp4;
    end

    always_comb begin
        off2  = {1'b0, r_sq5[CORR_W-1:1]} + (r_cold5 ? r_e7 : '0);
        sens2 = {2'b0, r_sq5[CORR_W-1:2]} + (r_cold5 ? {1'b0, r_e11[CORR_W-1:1]} : '0);
        n_out       = r_out;
        n_out.valid = r_v5;
        n_out.d1    = r_d1_5;
        n_out.temp  = r_temp5;
        n_out.off   = OFF_W'(r_off5) - $signed(r_warm_n5 ? off2 : '0);
        n_out.sens  = OFF_W'(r_sens5) - $signed(r_warm_n5 ? sens2 : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v4 <= i_first.valid;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1_4    <= i_first.d1;
        r_temp4   <= i_first.temp1;
        r_off4    <= i_first.off1;
        r_sens4   <= i_first.sens1;
        r_t2_4    <= i_first.t2;
        r_warm_n4 <= i_first.temp1 < TEMP_KNEE;
        r_cold4   <= i_first.temp1 < TEMP_COLD;
        r_dd      <= n_dd;
        r_ee      <= n_ee;

        r_d1_5    <= r_d1_4;
        r_temp5   <= n_temp5;
        r_off5    <= r_off4;
        r_sens5   <= r_sens4;
        r_warm_n5 <= r_warm_n4;
        r_cold5   <= r_cold4;
        r_sq5     <= n_sq5;
        r_e7      <= n_e7;
        r_e11     <= n_e11;

        r_out     <= n_out;
    end

    always_comb begin
        o_second       = r_out;
        o_second.valid = r_v6;
    end

endmodule

// ----- rtl/bptc_press.sv -----
// pressure: D1 times SENS in two partial products, shift, minus OFF
module bptc_press
    import bptc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_second                   i_second,
    output logic                      o_strobe,
    output logic signed [TEMP_W-1:0]  o_temperature_centi,
    output logic signed [PRESS_W-1:0] o_pressure_q15
);

    logic                    r_v7, r_v8, r_v9;
    logic signed [T1_W-1:0]  r_temp7, r_temp8;
    logic signed [OFF_W-1:0] r_off7, r_off8;
    logic [PLO_W-1:0]        r_plo, n_plo;
    logic signed [PHI_W-1:0] r_phi, n_phi;
    logic [PROD_W-1:0]       prod;
    logic [PRESS_W-1:0]      r_psh, n_psh, r_press, n_press;
    logic [TEMP_W-1:0]       r_temp9;

    always_comb begin
        n_plo = PLO_W'(i_second.d1) * PLO_W'(i_second.sens[SPLIT_W-1:0]);
        n_phi = $signed({1'b0, i_second.d1}) * $signed(i_second.sens[OFF_W-1:SPLIT_W]);
        // low bits of the exact product are enough for the wrapped result
        prod    = {r_phi, {SPLIT_W{1'b0}}} + PROD_W'(r_plo);
        n_psh   = prod[21 +: PRESS_W];
        n_press = r_psh - PRESS_W'(r_off8);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
            r_v9 <= 1'b0;
        end else begin
            r_v7 <= i_second.valid;
            r_v8 <= r_v7;
            r_v9 <= r_v8;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plo   <= n_plo;
        r_phi   <= n_phi;
        r_temp7 <= i_second.temp;
        r_off7  <= i_second.off;
        r_psh   <= n_psh;
        r_temp8 <= r_temp7;
        r_off8  <= r_off7;
        r_press <= n_press;
        r_temp9 <= r_temp8[TEMP_W-1:0];
    end

    assign o_strobe            = r_v9;
    assign o_temperature_centi = $signed(r_temp9);
    assign o_pressure_q15      = $signed(r_press);

endmodule

// ----- rtl/baro_pressure_temperature_compensation.sv -----
// barometer second-order compensation, top level with calibration registers
// each item passes the registered stages of bptc_first, bptc_second and bptc_press in turn;
// the strobe is high while its result is on the outputs
// throughput: one item per cycle once busy is low, set by the nine-stage pipeline with no feedback
// busy is set by reset and cleared by the first clock edge that sees reset released, low from then on
// reset clears the calibration words to zero and empties the pipeline; no result stall
module baro_pressure_temperature_compensation
    import bptc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [RAW_W-1:0]          i_raw_pressure,
    input  logic [RAW_W-1:0]          i_raw_temperature,
    input  logic                      i_cfg_we,
    input  logic [IDX_W-1:0]          i_cfg_index,
    input  logic [CAL_W-1:0]          i_cfg_data,
    output logic                      o_strobe,
    output logic signed [TEMP_W-1:0]  o_temperature_centi,
    output logic signed [PRESS_W-1:0] o_pressure_q15
);

    t_cal    r_cal, n_cal;
    logic    r_busy;
    t_first  first;
    t_second second;

    always_comb begin
        n_cal = r_cal;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SENS:     n_cal.sens     = i_cfg_data;
                CFG_OFF:      n_cal.off      = i_cfg_data;
                CFG_TCS:      n_cal.tcs      = i_cfg_data;
                CFG_TCO:      n_cal.tco      = i_cfg_data;
                CFG_TREF:     n_cal.tref     = i_cfg_data;
                CFG_TEMPSENS: n_cal.tempsens = i_cfg_data;
                default:      n_cal = r_cal;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal  <= '0;
            r_busy <= 1'b1;
        end else begin
            r_cal  <= n_cal;
            r_busy <= 1'b0;
        end
    end

    assign busy = r_busy;

    bptc_first u_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !r_busy),
        .i_d1    (i_raw_pressure),
        .i_d2    (i_raw_temperature),
        .i_cal   (r_cal),
        .o_first (first)
    );

    bptc_second u_second (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_first  (first),
        .o_second (second)
    );

    bptc_press u_press (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_second            (second),
        .o_strobe            (o_strobe),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_q15      (o_pressure_q15)
    );

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the barometer second-order compensation pipeline
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bptc_pkg::*;

    localparam int CAL_COUNT       = 6;
    localparam int RESET_CYCLES    = 11;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 40;
    localparam int RANDOM_PHASES   = 8;
    localparam int SAMPLES_PER_SET = 80;

    localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
    localparam logic [CAL_W-1:0] CAL_MAX = {CAL_W{1'b1}};

    // indexes past the last calibration word, writes there must be dropped
    localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic [CAL_W-1:0] TYPICAL_CAL [CAL_COUNT] =
        '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};

    typedef struct {
        logic [RAW_W-1:0] d1;
        logic [RAW_W-1:0] d2;
    } t_sample;

    typedef struct {
        logic signed [TEMP_W-1:0]  temp_centi;
        logic signed [PRESS_W-1:0] press_q15;
    } t_reading;

    logic                      i_clk             = 1'b0;
    logic                      i_rst_n           = 1'b0;
    logic                      start             = 1'b0;
    logic                      busy;
    logic [RAW_W-1:0]          i_raw_pressure    = '0;
    logic [RAW_W-1:0]          i_raw_temperature = '0;
    logic                      i_cfg_we          = 1'b0;
    logic [IDX_W-1:0]          i_cfg_index       = '0;
    logic [CAL_W-1:0]          i_cfg_data        = '0;
    logic                      o_strobe;
    logic signed [TEMP_W-1:0]  o_temperature_centi;
    logic signed [PRESS_W-1:0] o_pressure_q15;

    logic [CAL_W-1:0] cal_model [CAL_COUNT] = '{default: '0};
    t_sample          sample_q[$];
    t_reading         reading_q[$];
    int               idle_pct       = 0;
    int               sample_count   = 0;
    int               reading_count  = 0;
    int               mismatch_count = 0;
    int               cal_sets       = 1;
    int               quiet_cycles   = 0;

    baro_pressure_temperature_compensation uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_raw_pressure      (i_raw_pressure),
        .i_raw_temperature   (i_raw_temperature),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_strobe            (o_strobe),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_q15      (o_pressure_q15)
    );

    always #1 i_clk = ~i_clk;

    // 64-bit wrapping arithmetic, arithmetic right shifts
    function automatic t_reading compensate(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
        longint   dt, temp, off, sens, t2, dev, sq5, off2, sens2, cold, cold2, p;
        t_reading r;
        dt   = longint'(d2) - (longint'(cal_model[CFG_TREF]) <<< 8);
        temp = 2000 + ((longint'(cal_model[CFG_TEMPSENS]) * dt) >>> 23);
        off  = (longint'(cal_model[CFG_OFF]) <<< 16)
             + ((longint'(cal_model[CFG_TCO]) * dt) >>> 7);
        sens = (longint'(cal_model[CFG_SENS]) <<< 15)
             + ((longint'(cal_model[CFG_TCS]) * dt) >>> 8);
        if (temp < 2000) begin
            t2    = (dt * dt) >>> 31;
            dev   = temp - 2000;
            sq5   = 5 * dev * dev;
            off2  = sq5 >>> 1;
            sens2 = sq5 >>> 2;
            if (temp < -1500) begin
                cold  = temp + 1500;
                cold2 = cold * cold;
                off2  = off2 + 7 * cold2;
                sens2 = sens2 + ((11 * cold2) >>> 1);
            end
            temp = temp - t2;
            off  = off - off2;
            sens = sens - sens2;
        end
        p = ((longint'(d1) * sens) >>> 21) - off;
        r.temp_centi = temp[TEMP_W-1:0];
        r.press_q15  = p[PRESS_W-1:0];
        return r;
    endfunction

    task automatic load_cal(input logic [IDX_W-1:0] index, input logic [CAL_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        if (index <= CFG_TEMPSENS) begin
            cal_model[index] = value;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        t_sample s;
        s.d1 = d1;
        s.d2 = d2;
        sample_q.push_back(s);
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || reading_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // driver: the front of sample_q stays on the ports until it is taken
    always @(posedge i_clk) begin
        t_sample s;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                s = sample_q.pop_front();
                reading_q.push_back(compensate(s.d1, s.d2));
                sample_count++;
            end
            if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                start             <= 1'b1;
                i_raw_pressure    <= sample_q[0].d1;
                i_raw_temperature <= sample_q[0].d2;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_strobe) begin
            reading_count++;
            if (reading_q.size() == 0) begin
                if (mismatch_count < MAX_REPORTS) begin
                    $display("%0t: unexpected result, expected none, got temp %0d press %0d",
                             $time, o_temperature_centi, o_pressure_q15);
                end
                mismatch_count++;
            end else begin
                want = reading_q.pop_front();
                if (o_temperature_centi !== want.temp_centi) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("%0t: temperature_centi expected %0d got %0d",
                                 $time, want.temp_centi, o_temperature_centi);
                    end
                    mismatch_count++;
                end
                if (o_pressure_q15 !== want.press_q15) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("%0t: pressure_q15 expected %0d got %0d",
                                 $time, want.press_q15, o_pressure_q15);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: any handshake, result or register write counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, reading_q.size());
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int               phase;
        int               n;
        int               pick;
        logic [31:0]      near;
        logic [31:0]      rnd;
        logic [CAL_W-1:0] word;
        logic [RAW_W-1:0] d1;
        logic [RAW_W-1:0] d2;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // calibration still at its reset value of zero
        push_sample('0, '0);
        push_sample(RAW_MAX, RAW_MAX);
        push_sample(RAW_MAX, '0);
        push_sample('0, RAW_MAX);
        push_sample(24'h555555, 24'hAAAAAA);
        wait_drained();

        // tempsens of 2^15 gives temperature 2000 + dT/256, so the knees land on known dT
        load_cal(CFG_SENS, TYPICAL_CAL[CFG_SENS]);
        load_cal(CFG_OFF, TYPICAL_CAL[CFG_OFF]);
        load_cal(CFG_TCS, TYPICAL_CAL[CFG_TCS]);
        load_cal(CFG_TCO, TYPICAL_CAL[CFG_TCO]);
        load_cal(CFG_TREF, 16'd40000);
        load_cal(CFG_TEMPSENS, 16'd32768);
        load_cal(CFG_SPARE_LO, CAL_MAX);
        load_cal(CFG_SPARE_HI, CAL_MAX);
        cal_sets++;
        push_sample(24'd9085466, 24'd10240000);  // exactly 20.00 C, no correction
        push_sample(24'd9085466, 24'd10239999);  // just below the warm knee
        push_sample(24'd9085466, 24'd10239743);
        push_sample(24'd9085466, 24'd9344000);   // exactly -15.00 C, no extra term
        push_sample(24'd9085466, 24'd9343999);   // just below the cold knee
        push_sample(RAW_MAX, '0);
        push_sample('0, RAW_MAX);
        push_sample(RAW_MAX, RAW_MAX);
        wait_drained();

        for (int k = CFG_SENS; k <= CFG_TEMPSENS; k++) begin
            load_cal(k[IDX_W-1:0], CAL_MAX);
        end
        cal_sets++;
        push_sample('0, '0);
        push_sample(RAW_MAX, '0);
        push_sample('0, RAW_MAX);
        push_sample(RAW_MAX, RAW_MAX);
        wait_drained();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            idle_pct = (phase < 3) ? 16 : (phase < 6) ? 87 : 0;
            for (int k = CFG_SENS; k <= CFG_TEMPSENS; k++) begin
                rnd = $urandom;
                if (phase == 0) begin
                    word = TYPICAL_CAL[k];
                end else if (phase == 3) begin
                    word = '0;
                end else if (phase == 5) begin
                    word = CAL_MAX;
                end else begin
                    word = rnd[CAL_W-1:0];
                end
                load_cal(k[IDX_W-1:0], word);
            end
            if ($urandom_range(1) == 1) begin
                rnd = $urandom;
                load_cal(($urandom_range(1) == 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                         rnd[CAL_W-1:0]);
            end
            cal_sets++;

            for (n = 0; n < SAMPLES_PER_SET; n++) begin
                pick = $urandom_range(7);
                rnd  = $urandom;
                d1   = rnd[RAW_W-1:0];
                rnd  = $urandom;
                d2   = rnd[RAW_W-1:0];
                // most temperatures sit near the reference so both knees get crossed
                near = {8'h00, cal_model[CFG_TREF], 8'h00} + $urandom_range(1 << 22)
                     - (1 << 21);
                if (pick >= 2 && pick < 6) begin
                    d2 = near[RAW_W-1:0];
                end else if (pick == 6) begin
                    d1 = ($urandom_range(1) == 1) ? RAW_MAX : '0;
                    d2 = near[RAW_W-1:0];
                end else if (pick == 7) begin
                    d2 = ($urandom_range(1) == 1) ? RAW_MAX : '0;
                end
                push_sample(d1, d2);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d sample pairs checked against %0d results over %0d calibration sets",
                 sample_count, reading_count, cal_sets);
        $display("covered both temperature knees, raw and calibration extremes, and idle gaps");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- baro_pressure_temperature_compensation.f -----
rtl/bptc_pkg.sv
rtl/bptc_first.sv
rtl/bptc_second.sv
rtl/bptc_press.sv
rtl/baro_pressure_temperature_compensation.sv
tb/testbench.sv
